// ===== hdl/fpba_pkg.sv =====
// shared types and constants of the fit-policy block allocator
`timescale 1ns / 1ps
package fpba_pkg;

  // fixed field widths of the channels and the mode register
  localparam int KIND_W      = 1;
  localparam int IDX_FIELD_W = 4;
  localparam int AMT_W       = 16;
  localparam int MODE_W      = 2;

  // transaction kinds
  localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
  localparam logic [KIND_W-1:0] KIND_REQ  = 1'b1;

  // placement policies, the unused code behaves as first fit
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_t;

endpackage

// ===== hdl/fpba_in_if.sv =====
// input channel: load and request transactions
`timescale 1ns / 1ps
interface fpba_in_if;
  logic                               valid;
  logic                               ready;
  logic [fpba_pkg::KIND_W-1:0]        kind;
  logic [fpba_pkg::IDX_FIELD_W-1:0]   block_index;
  logic [fpba_pkg::AMT_W-1:0]         amount;

  modport source (output valid, kind, block_index, amount, input ready);
  modport sink   (input valid, kind, block_index, amount, output ready);
endinterface

// ===== hdl/fpba_out_if.sv =====
// result channel: grant reports
`timescale 1ns / 1ps
interface fpba_out_if;
  logic                               valid;
  logic                               ready;
  logic                               granted;
  logic [fpba_pkg::IDX_FIELD_W-1:0]   chosen_block;
  logic [fpba_pkg::AMT_W-1:0]         left_in_block;

  modport source (output valid, granted, chosen_block, left_in_block, input ready);
  modport sink   (input valid, granted, chosen_block, left_in_block, output ready);
endinterface

// ===== hdl/fpba_cell.sv =====
// one allocator cell: holds one block size and judges the passing search token
`timescale 1ns / 1ps
module fpba_cell #(
  parameter int SIZE_BITS = 16,
  parameter int IDX_W     = 4,
  parameter int CELL_IDX  = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [SIZE_BITS-1:0]          wr_data,
  input  logic                          upd_en,
  input  logic [fpba_pkg::AMT_W-1:0]    req_amount,
  input  logic [fpba_pkg::MODE_W-1:0]   mode,
  input  logic                          tok_in_valid,
  input  logic                          tok_in_found,
  input  logic [IDX_W-1:0]              tok_in_pick,
  input  logic [SIZE_BITS-1:0]          tok_in_best,
  output logic                          tok_out_valid,
  output logic                          tok_out_found,
  output logic [IDX_W-1:0]              tok_out_pick,
  output logic [SIZE_BITS-1:0]          tok_out_best
);

  localparam int CMP_W = (SIZE_BITS > fpba_pkg::AMT_W) ? SIZE_BITS : fpba_pkg::AMT_W;

  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic                 valid_r, found_r, found_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic [CMP_W-1:0]     size_ext, amt_ext, diff;
  logic                 fits, take;

  assign size_ext = CMP_W'(size_r);
  assign amt_ext  = CMP_W'(req_amount);
  assign fits     = (size_ext >= amt_ext);
  assign diff     = size_ext - amt_ext;

  // policy decision for this cell
  always_comb begin
    case (mode)
      fpba_pkg::FIT_BEST:  take = fits && (!tok_in_found || (tok_in_best > size_r));
      fpba_pkg::FIT_WORST: take = fits && (!tok_in_found || (tok_in_best < size_r));
      default:             take = fits && !tok_in_found;
    endcase
  end

  // token update
  always_comb begin
    found_nxt = tok_in_found;
    pick_nxt  = tok_in_pick;
    best_nxt  = tok_in_best;
    if (take) begin
      found_nxt = 1'b1;
      pick_nxt  = IDX_W'(CELL_IDX);
      best_nxt  = size_r;
    end
  end

  // block size: load or subtract the granted amount
  always_comb begin
    size_nxt = size_r;
    if (wr_en) begin
      size_nxt = wr_data;
    end else if (upd_en) begin
      size_nxt = SIZE_BITS'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      size_r  <= size_nxt;
      valid_r <= tok_in_valid;
    end
  end

  // token payload register toward the next cell
  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    pick_r  <= pick_nxt;
    best_r  <= best_nxt;
  end

  assign tok_out_valid = valid_r;
  assign tok_out_found = found_r;
  assign tok_out_pick  = pick_r;
  assign tok_out_best  = best_r;

endmodule

// ===== hdl/fit_policy_block_allocator.sv =====
// fit-policy block allocator: chain of size cells with a search token controller
//
// Usage:
//   in_chan carries transactions of two kinds. A load writes amount (truncated
//   to SIZE_BITS) into the block named by block_index and gives no result; an
//   index not below NUM_BLOCKS is dropped. A request searches all blocks under
//   the policy in the mode register: first fit, best fit or worst fit (ties to
//   the lowest index); the chosen block is reduced by amount.
//   out_chan returns one transaction per request: granted, chosen_block and
//   left_in_block (both zero when nothing fits).
//   cfg_wr_en/cfg_wr_data write the mode register; write it only while idle.
// Sequence:
//   a load is written into its cell as it is accepted. A request is registered
//   and passes a token down the row of NUM_BLOCKS cells, one cell per cycle;
//   the last cell's token is captured, then, when the output register is free,
//   the table is updated and the result registered; only then is input taken.
// Reset and stall:
//   reset clears all block sizes and sets first fit. A stalled receiver holds
//   the finished request until the output register is free; loads are still
//   taken while a result waits to be read.
`timescale 1ns / 1ps
module fit_policy_block_allocator #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  fpba_in_if.sink                       in_chan,
  fpba_out_if.source                    out_chan,
  input  logic                          cfg_wr_en,
  input  logic [fpba_pkg::MODE_W-1:0]   cfg_wr_data
);

  localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int IDXF_W = fpba_pkg::IDX_FIELD_W;
  localparam int AMT_W  = fpba_pkg::AMT_W;

  fpba_pkg::ctrl_state_t state_r, state_nxt;

  logic [fpba_pkg::MODE_W-1:0] mode_r;
  logic [AMT_W-1:0]            req_amount_r;
  logic                        launch_r;
  logic                        res_found_r;
  logic [IDX_W-1:0]            res_pick_r;
  logic [SIZE_BITS-1:0]        res_best_r;
  logic                        out_valid_r;
  logic                        out_granted_r;
  logic [IDXF_W-1:0]           out_block_r;
  logic [AMT_W-1:0]            out_left_r;

  logic in_fire, ld_fire, req_fire, ld_in_range;
  logic in_ready, capture, finish_fire, out_free;
  logic [SIZE_BITS-1:0] ld_data, left_val;

  // token chain, index 0 is the launch point
  logic                 tok_valid [0:NUM_BLOCKS];
  logic                 tok_found [0:NUM_BLOCKS];
  logic [IDX_W-1:0]     tok_pick  [0:NUM_BLOCKS];
  logic [SIZE_BITS-1:0] tok_best  [0:NUM_BLOCKS];

  // input handshake decode
  assign in_fire     = in_chan.valid && in_ready;
  assign ld_in_range = (32'(in_chan.block_index) < NUM_BLOCKS);
  assign ld_fire     = in_fire && (in_chan.kind == fpba_pkg::KIND_LOAD) && ld_in_range;
  assign req_fire    = in_fire && (in_chan.kind == fpba_pkg::KIND_REQ);
  assign ld_data     = SIZE_BITS'(in_chan.amount);
  assign out_free    = !out_valid_r || out_chan.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fpba_pkg::ST_IDLE:   if (req_fire) state_nxt = fpba_pkg::ST_SCAN;
      fpba_pkg::ST_SCAN:   if (tok_valid[NUM_BLOCKS]) state_nxt = fpba_pkg::ST_FINISH;
      fpba_pkg::ST_FINISH: if (out_free) state_nxt = fpba_pkg::ST_IDLE;
      default:             state_nxt = fpba_pkg::ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_ready    = 1'b0;
    capture     = 1'b0;
    finish_fire = 1'b0;
    unique case (state_r)
      fpba_pkg::ST_IDLE:   in_ready    = 1'b1;
      fpba_pkg::ST_SCAN:   capture     = tok_valid[NUM_BLOCKS];
      fpba_pkg::ST_FINISH: finish_fire = out_free;
      default:             in_ready    = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpba_pkg::ST_IDLE;
      mode_r      <= fpba_pkg::FIT_FIRST;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= req_fire;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (finish_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  assign left_val = res_best_r - SIZE_BITS'(req_amount_r);

  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_amount_r <= in_chan.amount;
    end
    if (capture) begin
      res_found_r <= tok_found[NUM_BLOCKS];
      res_pick_r  <= tok_pick[NUM_BLOCKS];
      res_best_r  <= tok_best[NUM_BLOCKS];
    end
    if (finish_fire) begin
      out_granted_r <= res_found_r;
      out_block_r   <= res_found_r ? IDXF_W'(res_pick_r) : '0;
      out_left_r    <= res_found_r ? AMT_W'(left_val) : '0;
    end
  end

  // token launch into the first cell
  assign tok_valid[0] = launch_r;
  assign tok_found[0] = 1'b0;
  assign tok_pick[0]  = '0;
  assign tok_best[0]  = '0;

  // row of cells
  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    logic wr_en, upd_en;

    assign wr_en  = ld_fire && (32'(in_chan.block_index) == i);
    assign upd_en = finish_fire && res_found_r && (res_pick_r == IDX_W'(i));

    fpba_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W),
      .CELL_IDX  (i)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .wr_en         (wr_en),
      .wr_data       (ld_data),
      .upd_en        (upd_en),
      .req_amount    (req_amount_r),
      .mode          (mode_r),
      .tok_in_valid  (tok_valid[i]),
      .tok_in_found  (tok_found[i]),
      .tok_in_pick   (tok_pick[i]),
      .tok_in_best   (tok_best[i]),
      .tok_out_valid (tok_valid[i+1]),
      .tok_out_found (tok_found[i+1]),
      .tok_out_pick  (tok_pick[i+1]),
      .tok_out_best  (tok_best[i+1])
    );
  end

  // channel outputs
  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.granted       = out_granted_r;
  assign out_chan.chosen_block  = out_block_r;
  assign out_chan.left_in_block = out_left_r;

endmodule
